// File: hdl/daeg_pkg.sv
// daeg_pkg: shared types and constants for the exposure grid
`default_nettype none
package daeg_pkg;

	localparam int ACC_W   = 48;
	localparam int SUM_W   = 56;
	localparam int EDGE_W  = 13;
	localparam int TICK_W  = 16;
	localparam int OVL_W   = 13;
	localparam int PROD_W  = 25;
	localparam int NUM_W   = 57;
	localparam int QUO_W   = 32;
	localparam int STEP_W  = 6;
	localparam int IMB_W   = 17;
	localparam int COORD_W = 4;

	localparam logic [STEP_W-1:0] CELL_DIV_STEPS = STEP_W'(QUO_W);
	localparam logic [STEP_W-1:0] IMB_DIV_STEPS  = STEP_W'(IMB_W);

	typedef struct packed {
		logic load;
		logic prep;
		logic rd;
		logic ov;
		logic prod;
		logic num;
		logic div_cell;
		logic upd;
		logic wmul;
		logic acc;
		logic imb_start;
		logic imb_take;
		logic imb_zero;
		logic clr_wr;
	} daeg_cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
		logic update;
		logic imb_skip;
	} daeg_sts_t;

endpackage
`default_nettype wire

// File: hdl/daeg_ram.sv
// daeg_ram: generic single write, single read RAM with registered read
`default_nettype none
module daeg_ram #(
	parameter int W     = 48,
	parameter int DEPTH = 256
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                             wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [W-1:0]                             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/daeg_div.sv
// daeg_div: restoring divider, one quotient bit per cycle
`default_nettype none
module daeg_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [daeg_pkg::ACC_W-1:0]  rem_init,
	input  wire logic [daeg_pkg::QUO_W-1:0]  low_init,
	input  wire logic [daeg_pkg::ACC_W-1:0]  divisor,
	input  wire logic [daeg_pkg::STEP_W-1:0] steps,
	output logic      [daeg_pkg::QUO_W-1:0]  quotient,
	output logic                             done
);
	import daeg_pkg::*;

	logic [ACC_W-1:0]  rem_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic [ACC_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [ACC_W:0]    trial;
	logic [ACC_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, low_q[QUO_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= steps;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			low_q <= low_init;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so it fits ACC_W bits
			rem_q <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule
`default_nettype wire

// File: hdl/daeg_dp.sv
// daeg_dp: cell walk datapath, accumulator store and statistics
`default_nettype none
module daeg_dp #(
	parameter int GRID_COLUMNS = 16,
	parameter int GRID_ROWS    = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire daeg_pkg::daeg_cmd_t          cmd,
	output daeg_pkg::daeg_sts_t               sts,
	input  wire logic [daeg_pkg::EDGE_W-1:0]  rect_left,
	input  wire logic [daeg_pkg::EDGE_W-1:0]  rect_top,
	input  wire logic [daeg_pkg::EDGE_W-1:0]  rect_right,
	input  wire logic [daeg_pkg::EDGE_W-1:0]  rect_bottom,
	input  wire logic [daeg_pkg::TICK_W-1:0]  elapsed_ticks,
	input  wire logic [daeg_pkg::COORD_W-1:0] read_column,
	input  wire logic [daeg_pkg::COORD_W-1:0] read_row,
	output logic      [daeg_pkg::SUM_W-1:0]   weighted_exposure,
	output logic      [daeg_pkg::SUM_W-1:0]   total_exposure,
	output logic      [daeg_pkg::COORD_W-1:0] least_column,
	output logic      [daeg_pkg::COORD_W-1:0] least_row,
	output logic      [daeg_pkg::COORD_W-1:0] most_column,
	output logic      [daeg_pkg::COORD_W-1:0] most_row,
	output logic      [daeg_pkg::IMB_W-1:0]   imbalance,
	output logic      [daeg_pkg::ACC_W-1:0]   cell_value
);
	import daeg_pkg::*;

	localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
	localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CIW   = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
	localparam int RIW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int XW    = 12 + $clog2(GRID_COLUMNS + 1);
	localparam int YW    = 12 + $clog2(GRID_ROWS + 1);
	localparam int DW    = XW + YW;
	localparam int OW    = 20;
	localparam logic [EDGE_W-1:0] UNIT = EDGE_W'(4096);

	function automatic logic [OVL_W-1:0] ovl(input logic [OW-1:0] lo, input logic [OW-1:0] hi,
		input logic [OW-1:0] c_lo);
		logic [OW-1:0] c_hi;
		logic [OW-1:0] a;
		logic [OW-1:0] b;
		c_hi = c_lo + OW'(4096);
		a    = (lo > c_lo) ? lo : c_lo;
		b    = (hi < c_hi) ? hi : c_hi;
		return (b > a) ? OVL_W'(b - a) : '0;
	endfunction

	function automatic logic [EDGE_W-1:0] clamp(input logic [EDGE_W-1:0] v);
		return (v > UNIT) ? UNIT : v;
	endfunction

	logic [XW-1:0]     xl_q, xr_q;
	logic [YW-1:0]     yt_q, yb_q;
	logic [TICK_W-1:0] elapsed_q;
	logic [COORD_W-1:0] rcol_q, rrow_q;
	logic              upd_q;
	logic [DW-1:0]     denom_q;
	logic [IW-1:0]     idx_q;
	logic [CIW-1:0]    col_q;
	logic [RIW-1:0]    row_q;
	logic [OVL_W-1:0]  ow_q, oh_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]  num_q;
	logic [ACC_W-1:0]  v_q;
	logic [ACC_W:0]    pa_q, pb_q;
	logic [SUM_W-1:0]  w_q, t_q;
	logic [ACC_W-1:0]  min_q, max_q, cell_q;
	logic [CIW-1:0]    min_col_q, max_col_q;
	logic [RIW-1:0]    min_row_q, max_row_q;
	logic [IMB_W-1:0]  imb_q;

	logic [ACC_W-1:0]  rdata;
	logic [ACC_W-1:0]  new_v;
	logic [ACC_W:0]    upd_sum;
	logic [2*OVL_W-1:0] prod_full;
	logic [TICK_W+PROD_W-1:0] ep;
	logic [ACC_W+1:0]  part;
	logic [SUM_W:0]    w_sum, t_sum;
	logic [ACC_W-1:0]  span;
	logic [QUO_W-1:0]  quotient;
	logic              div_done;
	logic              div_start;
	logic [ACC_W-1:0]  d_rem, d_dvs;
	logic [QUO_W-1:0]  d_low;
	logic [STEP_W-1:0] d_steps;
	logic              last;

	assign last = (idx_q == IW'(CELLS - 1));

	always_comb begin
		prod_full = ow_q * oh_q;
		ep        = (TICK_W+PROD_W)'(elapsed_q) * (TICK_W+PROD_W)'(prod_q);
		upd_sum   = {1'b0, v_q} + (ACC_W+1)'(quotient);
		new_v     = upd_sum[ACC_W] ? {ACC_W{1'b1}} : upd_sum[ACC_W-1:0];
		part      = (ACC_W+2)'(pa_q) + (ACC_W+2)'(pb_q >> 24);
		w_sum     = {1'b0, w_q} + (SUM_W+1)'(part);
		t_sum     = {1'b0, t_q} + (SUM_W+1)'(v_q);
		span      = max_q - min_q;
		div_start = cmd.div_cell | cmd.imb_start;
		if (cmd.imb_start) begin
			d_rem   = {1'b0, span[ACC_W-1:1]};
			d_low   = {span[0], {(QUO_W-1){1'b0}}};
			d_dvs   = max_q;
			d_steps = IMB_DIV_STEPS;
		end else begin
			d_rem   = ACC_W'(num_q[NUM_W-1:QUO_W]);
			d_low   = num_q[QUO_W-1:0];
			d_dvs   = ACC_W'(denom_q);
			d_steps = CELL_DIV_STEPS;
		end
	end

	daeg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (d_rem),
		.low_init (d_low),
		.divisor  (d_dvs),
		.steps    (d_steps),
		.quotient (quotient),
		.done     (div_done)
	);

	daeg_ram #(
		.W     (ACC_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.clr_wr | cmd.upd),
		.waddr (idx_q),
		.wdata (cmd.clr_wr ? '0 : new_v),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// cell walk counters, also used by the clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.prep) begin
			idx_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.clr_wr) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
		end else if (cmd.acc && !last) begin
			idx_q <= idx_q + 1'b1;
			if (col_q == CIW'(GRID_COLUMNS - 1)) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xl_q      <= XW'(clamp(rect_left)) * XW'(GRID_COLUMNS);
			xr_q      <= XW'(clamp(rect_right)) * XW'(GRID_COLUMNS);
			yt_q      <= YW'(clamp(rect_top)) * YW'(GRID_ROWS);
			yb_q      <= YW'(clamp(rect_bottom)) * YW'(GRID_ROWS);
			elapsed_q <= elapsed_ticks;
			rcol_q    <= read_column;
			rrow_q    <= read_row;
		end
		if (cmd.prep) begin
			upd_q   <= (xr_q > xl_q) && (yb_q > yt_q) && (elapsed_q != '0);
			denom_q <= DW'(xr_q - xl_q) * DW'(yb_q - yt_q);
			w_q     <= '0;
			t_q     <= '0;
			cell_q  <= '0;
		end
		if (cmd.ov) begin
			v_q  <= rdata;
			ow_q <= ovl(OW'(xl_q), OW'(xr_q), OW'(col_q) << 12);
			oh_q <= ovl(OW'(yt_q), OW'(yb_q), OW'(row_q) << 12);
		end
		if (cmd.prod) begin
			prod_q <= prod_full[PROD_W-1:0];
		end
		if (cmd.num) begin
			num_q <= {ep, 16'b0};
		end
		if (cmd.upd) begin
			v_q <= new_v;
		end
		if (cmd.wmul) begin
			pa_q <= v_q[ACC_W-1:24] * (ACC_W+1)'(prod_q);
			pb_q <= v_q[23:0] * (ACC_W+1)'(prod_q);
		end
		if (cmd.acc) begin
			w_q <= w_sum[SUM_W] ? {SUM_W{1'b1}} : w_sum[SUM_W-1:0];
			t_q <= t_sum[SUM_W] ? {SUM_W{1'b1}} : t_sum[SUM_W-1:0];
			if (idx_q == '0 || v_q < min_q) begin
				min_q     <= v_q;
				min_col_q <= col_q;
				min_row_q <= row_q;
			end
			if (idx_q == '0 || v_q > max_q) begin
				max_q     <= v_q;
				max_col_q <= col_q;
				max_row_q <= row_q;
			end
			if (7'(col_q) == 7'(rcol_q) && 7'(row_q) == 7'(rrow_q)) begin
				cell_q <= v_q;
			end
		end
		if (cmd.imb_take) begin
			imb_q <= quotient[IMB_W-1:0];
		end else if (cmd.imb_zero) begin
			imb_q <= '0;
		end
	end

	always_comb begin
		sts.last     = last;
		sts.div_done = div_done;
		sts.update   = upd_q;
		sts.imb_skip = (t_q == '0) || (max_q == '0);
	end

	assign weighted_exposure = w_q;
	assign total_exposure    = t_q;
	assign least_column      = COORD_W'(min_col_q);
	assign least_row         = COORD_W'(min_row_q);
	assign most_column       = COORD_W'(max_col_q);
	assign most_row          = COORD_W'(max_row_q);
	assign imbalance         = imb_q;
	assign cell_value        = cell_q;
endmodule
`default_nettype wire

// File: hdl/daeg_ctrl.sv
// daeg_ctrl: sequencer for the clearing pass and the per-request cell walk
`default_nettype none
module daeg_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire daeg_pkg::daeg_sts_t sts,
	output logic                     busy,
	output logic                     done,
	output daeg_pkg::daeg_cmd_t      cmd
);
	import daeg_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PREP, S_RD, S_OV, S_PROD, S_NUM, S_DIVS, S_DIVW,
		S_UPD, S_WMUL, S_ACC, S_IMB, S_IMBW, S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.last) state_d = S_IDLE;
			S_IDLE:  if (start) state_d = S_PREP;
			S_PREP:  state_d = S_RD;
			S_RD:    state_d = S_OV;
			S_OV:    state_d = S_PROD;
			S_PROD:  state_d = sts.update ? S_NUM : S_WMUL;
			S_NUM:   state_d = S_DIVS;
			S_DIVS:  state_d = S_DIVW;
			S_DIVW:  if (sts.div_done) state_d = S_UPD;
			S_UPD:   state_d = S_WMUL;
			S_WMUL:  state_d = S_ACC;
			S_ACC:   state_d = sts.last ? S_IMB : S_RD;
			S_IMB:   state_d = sts.imb_skip ? S_OUT : S_IMBW;
			S_IMBW:  if (sts.div_done) state_d = S_OUT;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_d == S_OUT);
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.prep      = (state_q == S_PREP);
		cmd.rd        = (state_q == S_RD);
		cmd.ov        = (state_q == S_OV);
		cmd.prod      = (state_q == S_PROD);
		cmd.num       = (state_q == S_NUM);
		cmd.div_cell  = (state_q == S_DIVS);
		cmd.upd       = (state_q == S_DIVW) ? 1'b0 : (state_q == S_UPD);
		cmd.wmul      = (state_q == S_WMUL);
		cmd.acc       = (state_q == S_ACC);
		cmd.imb_start = (state_q == S_IMB) && !sts.imb_skip;
		cmd.imb_zero  = (state_q == S_IMB) && sts.imb_skip;
		cmd.imb_take  = (state_q == S_IMBW) && sts.div_done;
		cmd.clr_wr    = (state_q == S_CLEAR);
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

// File: hdl/display_area_exposure_grid.sv
// display_area_exposure_grid: top level of the burn-in exposure grid
//
//   channel   handshake          fields
//   request   start / busy       rect_left..rect_bottom, elapsed_ticks, read_column, read_row
//   result    done (one cycle)   weighted_exposure .. cell_value
//
// After reset a clearing pass writes every cell, busy high.
// A request keeps busy high until done. With elapsed_ticks nonzero and a non-empty
// rectangle each cell takes a division; any other request skips it, and the imbalance
// division is skipped while no cell holds any exposure.
// The per-cell cost is set mostly by the one-bit-per-cycle divider.
// done is high for one cycle with all results; the receiver cannot stall.
`default_nettype none
module display_area_exposure_grid #(
	parameter int GRID_COLUMNS = 16,
	parameter int GRID_ROWS    = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	output logic                              done,
	input  wire logic [daeg_pkg::EDGE_W-1:0]  rect_left,
	input  wire logic [daeg_pkg::EDGE_W-1:0]  rect_top,
	input  wire logic [daeg_pkg::EDGE_W-1:0]  rect_right,
	input  wire logic [daeg_pkg::EDGE_W-1:0]  rect_bottom,
	input  wire logic [daeg_pkg::TICK_W-1:0]  elapsed_ticks,
	input  wire logic [daeg_pkg::COORD_W-1:0] read_column,
	input  wire logic [daeg_pkg::COORD_W-1:0] read_row,
	output logic      [daeg_pkg::SUM_W-1:0]   weighted_exposure,
	output logic      [daeg_pkg::SUM_W-1:0]   total_exposure,
	output logic      [daeg_pkg::COORD_W-1:0] least_column,
	output logic      [daeg_pkg::COORD_W-1:0] least_row,
	output logic      [daeg_pkg::COORD_W-1:0] most_column,
	output logic      [daeg_pkg::COORD_W-1:0] most_row,
	output logic      [daeg_pkg::IMB_W-1:0]   imbalance,
	output logic      [daeg_pkg::ACC_W-1:0]   cell_value
);
	import daeg_pkg::*;

	daeg_cmd_t cmd;
	daeg_sts_t sts;

	daeg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	daeg_dp #(
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_ROWS    (GRID_ROWS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.rect_left         (rect_left),
		.rect_top          (rect_top),
		.rect_right        (rect_right),
		.rect_bottom       (rect_bottom),
		.elapsed_ticks     (elapsed_ticks),
		.read_column       (read_column),
		.read_row          (read_row),
		.weighted_exposure (weighted_exposure),
		.total_exposure    (total_exposure),
		.least_column      (least_column),
		.least_row         (least_row),
		.most_column       (most_column),
		.most_row          (most_row),
		.imbalance         (imbalance),
		.cell_value        (cell_value)
	);

	// a result only ends a request in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but busy not raised");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !(cmd.upd || cmd.clr_wr))
		else $error("store written while idle");
endmodule
`default_nettype wire
